/* rtl/core/biquad_filter_q14_assert.svh */
// Assertion macros shared by the checker of the biquad filter.
// Each macro expects the signals clk and arst_n to be visible where it is used.
`ifndef BIQUAD_FILTER_Q14_ASSERT_SVH
`define BIQUAD_FILTER_Q14_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BFQ_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("biquad filter check failed");

// Next-cycle implication, disabled during reset.
`define BFQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("biquad filter check failed");

`endif

/* rtl/core/bfq_pkg.sv */
`default_nettype none

package bfq_pkg;

	// Field widths.
	localparam int SMP_W     = 32;
	localparam int COEF_W    = 16;
	localparam int PROD_W    = SMP_W + COEF_W;
	localparam int FIRST_W   = 50;
	localparam int SECOND_W  = 48;
	localparam int ACC_W     = 52;
	localparam int Q_SHIFT   = 14;
	localparam int SH_W      = ACC_W - Q_SHIFT;
	localparam int CFG_IDX_W = 3;

	// Rounding constant added before the Q14 shift.
	localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (Q_SHIFT - 1);

	// Saturation limits of the output sample.
	localparam logic [SMP_W-1:0] SAT_MAX = {1'b0, {(SMP_W-1){1'b1}}};
	localparam logic [SMP_W-1:0] SAT_MIN = {1'b1, {(SMP_W-1){1'b0}}};

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FF_COEF0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FF_COEF1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FF_COEF2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FB_COEF1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FB_COEF2 = 3'd4;

	// Reset values of the coefficients (unity gain pass-through).
	localparam logic [COEF_W-1:0] FF_COEF0_RST = 16'sd16384;

	// Operand pair fed to the shared multiplier.
	typedef enum logic [2:0] {
		MS_X_FF0 = 3'd0,
		MS_X_FF1 = 3'd1,
		MS_X_FF2 = 3'd2,
		MS_Y_FB1 = 3'd3,
		MS_Y_FB2 = 3'd4
	} mul_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     accept;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     y_en;
		logic     tmp_en;
		logic     tmp_add;
		logic     af_en;
		logic     as_en;
		logic     push;
	} cmd_t;

endpackage

`default_nettype wire

/* rtl/core/biquad_filter_q14.sv */
// Second-order IIR filter, transposed direct form II, signed Q14 coefficients.
// Sample channel: sample_valid/sample_stall carry sample_in, restart and
// block_end; a request is taken when valid is high and stall is low.
// Result channel: result_valid/result_stall carry sample_out and last, held
// steady while the receiver stalls.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high, indexes above four are ignored. Write only while idle.
// No sample is taken until the last result is pushed; the single shared 32 x 16
// multiplier forms the five products of each sample one after another.
// If the receiver stalls, the finished result waits in the output register,
// and a further result is held inside until that register drains; no sample
// is taken meanwhile.
// Reset clears the filter state, sets the coefficients to unity gain
// pass-through and leaves both channels empty.
`default_nettype none

module biquad_filter_q14 (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   sample_valid,
	output logic                                  sample_stall,
	input  wire  signed [bfq_pkg::SMP_W-1:0]      sample_in,
	input  wire                                   restart,
	input  wire                                   block_end,
	output logic                                  result_valid,
	input  wire                                   result_stall,
	output logic signed [bfq_pkg::SMP_W-1:0]      sample_out,
	output logic                                  last,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [bfq_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire  [bfq_pkg::COEF_W-1:0]            cfg_data
);
	import bfq_pkg::*;

	cmd_t cmd;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	// Sequencer.
	bfq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	// Arithmetic and storage.
	bfq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_valid & cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  (sample_in),
		.restart    (restart),
		.block_end  (block_end),
		.sample_out (sample_out),
		.last       (last)
	);

endmodule

`default_nettype wire

/* rtl/core/bfq_ctrl.sv */
`default_nettype none

module bfq_ctrl (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         sample_valid,
	output logic        sample_stall,
	output logic        result_valid,
	input  wire         result_stall,
	output bfq_pkg::cmd_t cmd
);
	import bfq_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MUL0 = 8'b0000_0010,
		ST_OUT  = 8'b0000_0100,
		ST_M1   = 8'b0000_1000,
		ST_M2   = 8'b0001_0000,
		ST_M3   = 8'b0010_0000,
		ST_M4   = 8'b0100_0000,
		ST_PUSH = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   result_valid_q;
	logic   out_free;

	// The output register can take a new result when empty or being drained.
	assign out_free     = !result_valid_q || !result_stall;
	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;

	// Next state and command decode.
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = MS_X_FF0;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_MUL0;
				end
			end
			ST_MUL0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_X_FF0;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				cmd.y_en    = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_X_FF1;
				state_d     = ST_M1;
			end
			ST_M1: begin
				cmd.tmp_en  = 1'b1;
				cmd.tmp_add = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_Y_FB1;
				state_d     = ST_M2;
			end
			ST_M2: begin
				cmd.af_en   = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_X_FF2;
				state_d     = ST_M3;
			end
			ST_M3: begin
				cmd.tmp_en  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_Y_FB2;
				state_d     = ST_M4;
			end
			ST_M4: begin
				cmd.as_en = 1'b1;
				state_d   = ST_PUSH;
			end
			ST_PUSH: begin
				if (out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/bfq_dp.sv */
`default_nettype none

module bfq_dp (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  bfq_pkg::cmd_t                            cmd,
	input  wire                                      cfg_we,
	input  wire  [bfq_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  wire  [bfq_pkg::COEF_W-1:0]               cfg_data,
	input  wire  signed [bfq_pkg::SMP_W-1:0]         sample_in,
	input  wire                                      restart,
	input  wire                                      block_end,
	output logic signed [bfq_pkg::SMP_W-1:0]         sample_out,
	output logic                                     last
);
	import bfq_pkg::*;

	logic signed [COEF_W-1:0]   ff0_q, ff1_q, ff2_q, fb1_q, fb2_q;
	logic signed [SMP_W-1:0]    x_q;
	logic signed [SMP_W-1:0]    y_q;
	logic                       be_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [FIRST_W-1:0]  tmp_q;
	logic signed [FIRST_W-1:0]  af_q;
	logic signed [SECOND_W-1:0] as_q;
	logic signed [SMP_W-1:0]    sample_out_q;
	logic                       last_q;

	logic signed [SMP_W-1:0]    mul_a;
	logic signed [COEF_W-1:0]   mul_b;
	logic        [ACC_W-1:0]    acc_sum;
	logic        [SH_W-1:0]     acc_sh;
	logic                       acc_ovf;
	logic        [SMP_W-1:0]    y_d;
	logic        [FIRST_W-1:0]  prod_ext;
	logic        [FIRST_W-1:0]  as_ext;

	// Coefficient registers, written through the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff0_q <= FF_COEF0_RST;
			ff1_q <= '0;
			ff2_q <= '0;
			fb1_q <= '0;
			fb2_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FF_COEF0: ff0_q <= cfg_data;
				CFG_FF_COEF1: ff1_q <= cfg_data;
				CFG_FF_COEF2: ff2_q <= cfg_data;
				CFG_FB_COEF1: fb1_q <= cfg_data;
				CFG_FB_COEF2: fb2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Operand selection for the shared 32 x 16 multiplier.
	always_comb begin
		case (cmd.mul_sel)
			MS_X_FF0: begin mul_a = x_q; mul_b = ff0_q; end
			MS_X_FF1: begin mul_a = x_q; mul_b = ff1_q; end
			MS_X_FF2: begin mul_a = x_q; mul_b = ff2_q; end
			MS_Y_FB1: begin mul_a = y_q; mul_b = fb1_q; end
			MS_Y_FB2: begin mul_a = y_q; mul_b = fb2_q; end
			default:  begin mul_a = x_q; mul_b = ff0_q; end
		endcase
	end

	// Round, shift to Q0 and clamp to the signed 32-bit range.
	always_comb begin
		acc_sum = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q}
			+ {{(ACC_W-FIRST_W){af_q[FIRST_W-1]}}, af_q}
			+ RND_HALF;
		acc_sh  = acc_sum[ACC_W-1:Q_SHIFT];
		acc_ovf = !((&acc_sh[SH_W-1:SMP_W-1]) || !(|acc_sh[SH_W-1:SMP_W-1]));
		if (acc_ovf) begin
			y_d = acc_sh[SH_W-1] ? SAT_MIN : SAT_MAX;
		end else begin
			y_d = acc_sh[SMP_W-1:0];
		end
	end

	// Sign extensions used by the state updates.
	assign prod_ext = {{(FIRST_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign as_ext   = {{(FIRST_W-SECOND_W){as_q[SECOND_W-1]}}, as_q};

	// Sample latch, product register, partial sum, output sample and result register.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q  <= sample_in;
			be_q <= block_end;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.y_en) begin
			y_q <= y_d;
		end
		if (cmd.tmp_en) begin
			tmp_q <= cmd.tmp_add ? (as_ext + prod_ext) : prod_ext;
		end
		if (cmd.push) begin
			sample_out_q <= y_q;
			last_q       <= be_q;
		end
	end

	// Filter state; a restart request clears it before its sample is used.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			af_q <= '0;
			as_q <= '0;
		end else begin
			if (cmd.accept && restart) begin
				af_q <= '0;
				as_q <= '0;
			end
			if (cmd.af_en) begin
				af_q <= tmp_q + prod_ext;
			end
			if (cmd.as_en) begin
				as_q <= tmp_q[SECOND_W-1:0] + prod_q;
			end
		end
	end

	assign sample_out = sample_out_q;
	assign last       = last_q;

endmodule

`default_nettype wire

/* rtl/core/bfq_checker.sv */
`default_nettype none

`include "biquad_filter_q14_assert.svh"

module bfq_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                sample_valid,
	input wire                                sample_stall,
	input wire                                result_valid,
	input wire                                result_stall,
	input wire signed [bfq_pkg::SMP_W-1:0]    sample_out,
	input wire                                last,
	input wire                                cfg_valid,
	input wire                                cfg_ready
);

	// A stalled result keeps its value.
	`BFQ_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(sample_out) && $stable(last))

	// After a sample is taken the block is busy with it.
	`BFQ_ASSERT_NEXT(a_busy_after_accept, sample_valid && !sample_stall, sample_stall)

	// A new result only appears at the end of work on a sample.
	`BFQ_ASSERT_SAME(a_result_from_work, $rose(result_valid), $past(sample_stall))

	// The configuration port never pushes back.
	`BFQ_ASSERT_SAME(a_cfg_always_ready, cfg_valid, cfg_ready)

endmodule

bind biquad_filter_q14 bfq_checker u_bfq_checker (.*);

`default_nettype wire

/* bench/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bfq_pkg::*;

	localparam int IDLE_PCT       = 13;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 130;
	localparam int QUIET_PHASE    = 3;

	localparam logic signed [SMP_W-1:0] X_MAX = SAT_MAX;
	localparam logic signed [SMP_W-1:0] X_MIN = SAT_MIN;

	// Highest index the configuration port can carry; those above the last
	// coefficient must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

	localparam logic [COEF_W-1:0] COEF_POS_MAX = 16'h7FFF;
	localparam logic [COEF_W-1:0] COEF_NEG_MAX = 16'h8000;
	localparam logic [COEF_W-1:0] COEF_UNITY   = FF_COEF0_RST;

	typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;
	typedef enum logic [1:0] {COEF_MILD, COEF_ANY, COEF_EDGE} coef_style_t;

	typedef struct {
		row_kind_t               kind;
		logic [CFG_IDX_W-1:0]    idx;
		logic [SMP_W-1:0]        value;
		logic                    rst;
		logic                    blk;
		logic                    known;
		logic signed [SMP_W-1:0] want;
	} stim_row_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] smp;
		logic                    lst;
	} filtered_t;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    sample_valid = 1'b0;
	logic                    sample_stall;
	logic signed [SMP_W-1:0] sample_in    = '0;
	logic                    restart      = 1'b0;
	logic                    block_end    = 1'b0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic signed [SMP_W-1:0] sample_out;
	logic                    last;
	logic                    cfg_valid    = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index    = '0;
	logic [COEF_W-1:0]       cfg_data     = '0;

	// Predictor copy of the coefficients and of the two filter state registers.
	logic signed [COEF_W-1:0]   coef [0:4];
	logic signed [FIRST_W-1:0]  state_first  = '0;
	logic signed [SECOND_W-1:0] state_second = '0;

	filtered_t filtered_q [$];
	stim_row_t plan [$];
	int        errors      = 0;
	int        quiet_cycles = 0;
	bit        no_idle     = 1'b0;

	biquad_filter_q14 dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_in    (sample_in),
		.restart      (restart),
		.block_end    (block_end),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sample_out   (sample_out),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One filter step: round and saturate b0*x + s0, then update both states
	// from the clamped output, wrapping them at their register widths.
	function automatic logic signed [SMP_W-1:0] biquad_predict(logic signed [SMP_W-1:0] x,
			logic clear);
		longint acc;
		longint y;
		if (clear) begin
			state_first  = '0;
			state_second = '0;
		end
		acc = longint'(x) * longint'(coef[CFG_FF_COEF0]) + longint'(state_first);
		y   = (acc + longint'(RND_HALF)) >>> Q_SHIFT;
		if (y > longint'(X_MAX))
			y = longint'(X_MAX);
		if (y < longint'(X_MIN))
			y = longint'(X_MIN);
		state_first  = FIRST_W'(longint'(state_second)
				+ longint'(coef[CFG_FF_COEF1]) * longint'(x)
				+ longint'(coef[CFG_FB_COEF1]) * y);
		state_second = SECOND_W'(longint'(coef[CFG_FF_COEF2]) * longint'(x)
				+ longint'(coef[CFG_FB_COEF2]) * y);
		return SMP_W'(y);
	endfunction

	function automatic stim_row_t smp_row(logic [SMP_W-1:0] x, logic rst, logic blk,
			logic known, logic [SMP_W-1:0] want);
		stim_row_t r;
		r.kind  = ROW_SAMPLE;
		r.idx   = '0;
		r.value = x;
		r.rst   = rst;
		r.blk   = blk;
		r.known = known;
		r.want  = want;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
		stim_row_t r;
		r.kind  = ROW_CFG;
		r.idx   = idx;
		r.value = SMP_W'(value);
		r.rst   = 1'b0;
		r.blk   = 1'b0;
		r.known = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	// Mild coefficients keep the filter stable; the other styles drive it hard into
	// saturation and wrap.
	function automatic logic [COEF_W-1:0] pick_coef(coef_style_t style, logic feedback);
		case (style)
			COEF_MILD: begin
				if (feedback)
					return COEF_W'(int'($urandom_range(0, 16000)) - 8000);
				return COEF_W'(int'($urandom_range(0, 32768)) - 16384);
			end
			COEF_EDGE: begin
				case ($urandom_range(0, 3))
					0: return COEF_POS_MAX;
					1: return COEF_NEG_MAX;
					2: return COEF_UNITY;
					default: return '0;
				endcase
			end
			default: return COEF_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [SMP_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return X_MAX;
			1: return X_MIN;
			2, 3: return SMP_W'($urandom);
			default: return SMP_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
	endtask

	// Leaves cfg_valid high; the next sample request lowers it.
	task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx <= CFG_FB_COEF2)
			coef[idx] = value;
	endtask

	// Sends one sample request, holding valid high afterwards so that the next
	// request can follow back to back.
	task automatic send_sample(logic signed [SMP_W-1:0] x, logic rst, logic blk,
			logic known, logic signed [SMP_W-1:0] want);
		filtered_t               item;
		logic signed [SMP_W-1:0] model_y;
		cfg_valid <= 1'b0;
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_in    <= x;
		restart      <= rst;
		block_end    <= blk;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		model_y  = biquad_predict(x, rst);
		item.smp = known ? want : model_y;
		item.lst = blk;
		filtered_q.push_back(item);
	endtask

	// The filter is idle once every result has drained and it will take a sample.
	task automatic wait_until_idle();
		sample_valid <= 1'b0;
		while (filtered_q.size() != 0)
			@(posedge clk);
		while (sample_stall)
			@(posedge clk);
	endtask

	// Receiver side stalls at random, except in the quiet phase.
	always @(posedge clk) begin
		result_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Each accepted result is checked against the oldest pending expectation.
	always @(posedge clk) begin
		filtered_t head;
		if (arst_n && result_valid && !result_stall) begin
			if (filtered_q.size() == 0) begin
				report_mismatch("result with no sample pending", sample_out, 0);
			end else begin
				head = filtered_q.pop_front();
				if (sample_out !== head.smp)
					report_mismatch("sample_out", sample_out, head.smp);
				if (last !== head.lst)
					report_mismatch("last", last, head.lst);
			end
		end
	end

	// Ends the run if no request moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		coef_style_t style;
		coef[CFG_FF_COEF0] = COEF_UNITY;
		coef[CFG_FF_COEF1] = '0;
		coef[CFG_FF_COEF2] = '0;
		coef[CFG_FB_COEF1] = '0;
		coef[CFG_FB_COEF2] = '0;

		// Pass-through after reset: each output equals its input.
		plan.push_back(smp_row('0, 1'b1, 1'b0, 1'b1, '0));
		plan.push_back(smp_row(32'd1, 1'b0, 1'b0, 1'b1, 32'd1));
		plan.push_back(smp_row('1, 1'b0, 1'b1, 1'b1, '1));
		plan.push_back(smp_row(SAT_MAX, 1'b0, 1'b0, 1'b1, SAT_MAX));
		plan.push_back(smp_row(SAT_MIN, 1'b0, 1'b1, 1'b1, SAT_MIN));
		plan.push_back(smp_row(32'h5555_5555, 1'b0, 1'b0, 1'b1, 32'h5555_5555));
		plan.push_back(smp_row(32'hAAAA_AAAA, 1'b1, 1'b1, 1'b1, 32'hAAAA_AAAA));
		// A gain just under two saturates a full-scale input high.
		plan.push_back(cfg_row(CFG_FF_COEF0, COEF_POS_MAX));
		plan.push_back(smp_row(SAT_MAX, 1'b1, 1'b0, 1'b1, SAT_MAX));
		// A gain of minus two saturates in both directions.
		plan.push_back(cfg_row(CFG_FF_COEF0, COEF_NEG_MAX));
		plan.push_back(smp_row(SAT_MIN, 1'b1, 1'b0, 1'b1, SAT_MAX));
		plan.push_back(smp_row(SAT_MAX, 1'b1, 1'b1, 1'b1, SAT_MIN));
		// Every coefficient at full scale.
		plan.push_back(cfg_row(CFG_FF_COEF1, COEF_POS_MAX));
		plan.push_back(cfg_row(CFG_FF_COEF2, COEF_NEG_MAX));
		plan.push_back(cfg_row(CFG_FB_COEF1, COEF_NEG_MAX));
		plan.push_back(cfg_row(CFG_FB_COEF2, COEF_POS_MAX));
		plan.push_back(smp_row(SAT_MAX, 1'b1, 1'b0, 1'b0, '0));
		plan.push_back(smp_row(SAT_MIN, 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(smp_row(32'd12345, 1'b0, 1'b1, 1'b0, '0));
		plan.push_back(smp_row('0, 1'b0, 1'b0, 1'b0, '0));
		// Both second-state products at their most positive wrap that register.
		plan.push_back(cfg_row(CFG_FF_COEF0, COEF_UNITY));
		plan.push_back(cfg_row(CFG_FF_COEF1, '0));
		plan.push_back(cfg_row(CFG_FB_COEF1, '0));
		plan.push_back(cfg_row(CFG_FF_COEF2, COEF_NEG_MAX));
		plan.push_back(cfg_row(CFG_FB_COEF2, COEF_NEG_MAX));
		plan.push_back(smp_row(SAT_MIN, 1'b1, 1'b0, 1'b1, SAT_MIN));
		plan.push_back(smp_row('0, 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(smp_row('0, 1'b0, 1'b1, 1'b0, '0));
		// Writes above the last coefficient index change nothing.
		plan.push_back(cfg_row(CFG_IDX_W'(CFG_FB_COEF2 + 1), '1));
		plan.push_back(cfg_row(CFG_IDX_W'(CFG_FB_COEF2 + 2), '1));
		plan.push_back(cfg_row(CFG_IDX_TOP, '1));
		plan.push_back(smp_row(32'd100, 1'b1, 1'b0, 1'b0, '0));
		plan.push_back(smp_row(SAT_MIN, 1'b0, 1'b1, 1'b0, '0));

		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				wait_until_idle();
				write_coef(plan[i].idx, plan[i].value[COEF_W-1:0]);
			end else begin
				send_sample(plan[i].value, plan[i].rst, plan[i].blk, plan[i].known,
						plan[i].want);
			end
		end

		// Random phases, each with a fresh set of coefficients.
		for (int p = 0; p < PHASES; p++) begin
			wait_until_idle();
			style = coef_style_t'(p % 3);
			for (int i = CFG_FF_COEF0; i <= CFG_FB_COEF2; i++)
				write_coef(CFG_IDX_W'(i), pick_coef(style, i >= CFG_FB_COEF1));
			if ($urandom_range(0, 3) == 0)
				write_coef(CFG_IDX_W'($urandom_range(CFG_FB_COEF2 + 1, CFG_IDX_TOP)),
						COEF_W'($urandom));
			no_idle = (p == QUIET_PHASE);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_sample(pick_sample(), $urandom_range(0, 19) == 0,
						$urandom_range(0, 7) == 0, 1'b0, '0);
		end
		no_idle = 1'b0;

		wait_until_idle();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
